[src/b64se_pkg.sv]
// Package for the base64 stream encoder: types, constants and the sextet map.
`default_nettype none
package b64se_pkg;

    // Widths of the channel payloads
    localparam int BYTE_W = 8;
    localparam int CHAR_W = 7;
    localparam int CHARS_PER_ENTRY = 4;

    // Queue between the front and back parts
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);

    // Padding character '='
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    // Byte position within the current 3-byte group
    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } t_phase;

    // One queued entry: up to four characters produced by one byte
    typedef struct packed {
        logic [CHARS_PER_ENTRY-1:0][CHAR_W-1:0] chars;
        logic [1:0]                             cnt_m1; // characters held, minus one
        logic                                   eom;    // final char ends the message
    } t_entry;

    // Queue control from the front part
    typedef struct packed {
        logic   push;
        t_entry data;
    } t_push;

    // Queue status towards the consumers
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Map a 6-bit group onto the '+' '/' alphabet
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h61 + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 7'h30 + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[src/b64se_channels.sv]
// Channel interfaces of the base64 stream encoder: byte input and character output.
`default_nettype none
interface b64se_in_if;
    logic                          valid;
    logic                          ready;
    logic [b64se_pkg::BYTE_W-1:0]  data_byte;
    logic                          end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64se_out_if;
    logic                          valid;
    logic                          ready;
    logic [b64se_pkg::CHAR_W-1:0]  out_char;
    logic                          last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

[src/base64_stream_encoder_unit.sv]
// Top level of the base64 stream encoder: front part, entry queue and back part.
//
// Usage:
//   i_in carries one message byte per transfer (data_byte) with end_of_message set
//   on the final byte. o_out carries one ASCII character per transfer (out_char),
//   with last_char set on the final character of each encoded message. Characters
//   are sent as soon as their 6-bit groups are complete; the message total is a
//   multiple of four, '=' padding included.
//   A byte's characters pass through a queue entry and then the back holding register.
//   The output sends one character per cycle while the receiver is ready, so a byte
//   takes as long as the characters it yields: 1 or 2 within a message, 2 to 4 on the
//   final byte; 4 characters per 3 bytes. The output port sets the pace.
//   A two-entry queue lets bytes be taken while earlier characters still wait.
//   Reset (i_rst_n low, synchronous) empties the queue and returns the group phase
//   to the start of a message. When the receiver stalls, the current character
//   holds; once the queue is full, i_in.ready falls until an entry is drained.
`default_nettype none
module base64_stream_encoder_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b64se_in_if.sink    i_in,
    b64se_out_if.source o_out
);

    b64se_pkg::t_push  w_push;
    b64se_pkg::t_qstat w_qstat;
    b64se_pkg::t_entry w_head;
    logic              w_pop;

    b64se_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push)
    );

    b64se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    b64se_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[src/b64se_front.sv]
// Front part: accepts bytes, tracks the group phase and builds the character entries.
`default_nettype none
module b64se_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    b64se_in_if.sink               i_in,
    input  wire b64se_pkg::t_qstat i_qstat,
    output b64se_pkg::t_push       o_push
);

    b64se_pkg::t_phase r_phase, n_phase;
    logic [3:0]        r_left, n_left;
    logic              w_take;
    logic [7:0]        w_b;
    logic              w_eom;

    assign i_in.ready = !i_qstat.full;
    assign w_take     = i_in.valid && !i_qstat.full;
    assign w_b        = i_in.data_byte;
    assign w_eom      = i_in.end_of_message;

    // Phase and leftover bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64se_pkg::PH0;
            r_left  <= 4'd0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    // Characters completed by this byte, next phase
    always_comb begin
        o_push.push         = w_take;
        o_push.data.chars   = '0;
        o_push.data.cnt_m1  = 2'd0;
        o_push.data.eom     = w_eom;
        n_phase             = b64se_pkg::PH0;
        n_left              = 4'd0;
        case (r_phase)
            b64se_pkg::PH1: begin
                o_push.data.chars[0] = b64se_pkg::sextet_char({r_left[1:0], w_b[7:4]});
                if (w_eom) begin
                    o_push.data.chars[1] = b64se_pkg::sextet_char({w_b[3:0], 2'b00});
                    o_push.data.chars[2] = b64se_pkg::PAD_CHAR;
                    o_push.data.cnt_m1   = 2'd2;
                end else begin
                    n_phase = b64se_pkg::PH2;
                    n_left  = w_b[3:0];
                end
            end
            b64se_pkg::PH2: begin
                o_push.data.chars[0] = b64se_pkg::sextet_char({r_left, w_b[7:6]});
                o_push.data.chars[1] = b64se_pkg::sextet_char(w_b[5:0]);
                o_push.data.cnt_m1   = 2'd1;
            end
            default: begin
                // phase 0, and the unused code treated the same
                o_push.data.chars[0] = b64se_pkg::sextet_char(w_b[7:2]);
                if (w_eom) begin
                    o_push.data.chars[1] = b64se_pkg::sextet_char({w_b[1:0], 4'b0000});
                    o_push.data.chars[2] = b64se_pkg::PAD_CHAR;
                    o_push.data.chars[3] = b64se_pkg::PAD_CHAR;
                    o_push.data.cnt_m1   = 2'd3;
                end else begin
                    n_phase = b64se_pkg::PH1;
                    n_left  = {2'b00, w_b[1:0]};
                end
            end
        endcase
    end

endmodule
`default_nettype wire

[src/b64se_queue.sv]
// Short entry queue between the front and back parts.
`default_nettype none
module b64se_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64se_pkg::t_push  i_push,
    input  wire logic              i_pop,
    output b64se_pkg::t_entry      o_head,
    output b64se_pkg::t_qstat      o_qstat
);

    localparam int AW = b64se_pkg::QAW;

    b64se_pkg::t_entry r_mem [b64se_pkg::QDEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [AW:0]       r_cnt;
    logic              w_wr, w_rd;

    assign o_qstat.full  = (r_cnt == (AW+1)'(b64se_pkg::QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign w_wr          = i_push.push && !o_qstat.full;
    assign w_rd          = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (w_rd) begin
                r_rptr <= r_rptr + AW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/b64se_back.sv]
// Back part: takes entries from the queue and sends their characters one per transfer.
`default_nettype none
module b64se_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64se_pkg::t_entry i_head,
    input  wire b64se_pkg::t_qstat i_qstat,
    output logic                   o_pop,
    b64se_out_if.source            o_out
);

    b64se_pkg::t_entry r_entry;
    logic              r_busy;
    logic [1:0]        r_idx;
    logic              w_done, w_xfer, w_final;

    assign w_final        = (r_idx == r_entry.cnt_m1);
    assign w_xfer         = r_busy && o_out.ready;
    assign w_done         = !r_busy || (w_xfer && w_final);
    assign o_pop          = w_done && !i_qstat.empty;

    assign o_out.valid     = r_busy;
    assign o_out.out_char  = r_entry.chars[r_idx];
    assign o_out.last_char = r_entry.eom && w_final;

    // Entry holding register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_head;
        end
    end

    // Character index and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_done) begin
            r_busy <= !i_qstat.empty;
            r_idx  <= 2'd0;
        end else if (w_xfer) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

endmodule
`default_nettype wire
